### hw/rtl/bffa_pkg.sv
// Shared types and constants for the first-fit bitmap allocator.
`timescale 1ns / 1ps

package bffa_pkg;

  localparam int NUM_ENTRIES_DEF = 32768;
  localparam int WORD_BITS_DEF   = 32;

  localparam int IDX_W    = 15;
  localparam int LIMIT_W  = 16;
  localparam int TDATA_W  = 16;
  localparam int TUSER_W  = 1;
  localparam int RECIP_SH = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'h8000;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_FREE_ADR,
    ST_FREE_RD,
    ST_FREE_MOD,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic div;
    logic free_adr;
    logic free_rd;
    logic free_mod;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic found;
    logic exhausted;
    logic out_free;
  } dp_stat_t;

endpackage

### hw/rtl/bffa_ctrl.sv
// Controller state machine of the bitmap allocator.
`timescale 1ns / 1ps

module bffa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_req,
  output logic                  in_tready,
  input  bffa_pkg::dp_stat_t    stat,
  output bffa_pkg::ctrl_cmd_t   cmd
);

  bffa_pkg::state_t state_r;
  bffa_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bffa_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      bffa_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_done) begin
          state_nxt = bffa_pkg::ST_IDLE;
        end
      end
      bffa_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_req == bffa_pkg::REQ_FREE) ? bffa_pkg::ST_DIV : bffa_pkg::ST_SCAN;
        end
      end
      bffa_pkg::ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = bffa_pkg::ST_FREE_ADR;
      end
      bffa_pkg::ST_FREE_ADR: begin
        cmd.free_adr = 1'b1;
        state_nxt    = bffa_pkg::ST_FREE_RD;
      end
      bffa_pkg::ST_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = bffa_pkg::ST_FREE_MOD;
      end
      bffa_pkg::ST_FREE_MOD: begin
        cmd.free_mod = 1'b1;
        state_nxt    = bffa_pkg::ST_FINISH;
      end
      bffa_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.found || stat.exhausted) begin
          state_nxt = bffa_pkg::ST_FINISH;
        end
      end
      bffa_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = bffa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bffa_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

### hw/rtl/bffa_dpath.sv
// Datapath of the bitmap allocator: map memory, scan counters, index math, output register.
`timescale 1ns / 1ps

module bffa_dpath #(
  parameter int NUM_ENTRIES = bffa_pkg::NUM_ENTRIES_DEF,
  parameter int WORD_BITS   = bffa_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bffa_pkg::LIMIT_W-1:0]  cfg_wr_data,
  input  logic [bffa_pkg::IDX_W-1:0]    in_index,
  input  bffa_pkg::ctrl_cmd_t           cmd,
  output bffa_pkg::dp_stat_t            stat,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic                          out_status,
  output logic [bffa_pkg::IDX_W-1:0]    out_index
);

  localparam int MapWords = (NUM_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int AddrW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int BitW     = $clog2(WORD_BITS);
  localparam int LimW     = $clog2(NUM_ENTRIES + 1);
  localparam int CntW     = LimW + 1;
  localparam int ProdW    = bffa_pkg::IDX_W + bffa_pkg::RECIP_SH;
  localparam longint unsigned Recip = (64'd1 << bffa_pkg::RECIP_SH) / WORD_BITS;
  localparam int IdxW     = bffa_pkg::IDX_W;

  logic [WORD_BITS-1:0] mem [MapWords];

  logic [bffa_pkg::LIMIT_W-1:0] lim_cfg_r;
  logic [LimW-1:0]              lim_r;
  logic [IdxW-1:0]              idx_r;
  logic [IdxW-1:0]              q_r;
  logic [AddrW-1:0]             word_r;
  logic [BitW-1:0]              bit_r;
  logic                         inrange_r;
  logic [AddrW:0]               rd_w_r;
  logic [CntW-1:0]              base_rd_r;
  logic [AddrW-1:0]             word_chk_r;
  logic [CntW-1:0]              base_chk_r;
  logic                         chk_vld_r;
  logic [WORD_BITS-1:0]         rd_data_r;
  logic [AddrW-1:0]             wr_word_r;
  logic [WORD_BITS-1:0]         wr_data_r;
  logic                         wr_pend_r;
  logic                         res_status_r;
  logic [IdxW-1:0]              res_idx_r;
  logic                         out_vld_r;
  logic                         out_status_r;
  logic [IdxW-1:0]              out_idx_r;
  logic [AddrW-1:0]             clr_cnt_r;

  logic [LimW-1:0]      lim_sat;
  logic [ProdW-1:0]     prod;
  logic [IdxW-1:0]      rem;
  logic                 rd_issue;
  logic [CntW-1:0]      span;
  logic [WORD_BITS-1:0] span_mask;
  logic [WORD_BITS-1:0] avail;
  logic [BitW-1:0]      low_b;
  logic [CntW-1:0]      grant;
  logic                 found;
  logic                 exhausted;
  logic                 mem_we;
  logic [AddrW-1:0]     mem_wa;
  logic [WORD_BITS-1:0] mem_wd;
  logic                 mem_re;
  logic [AddrW-1:0]     mem_ra;

  // Limit saturated to the map size, sampled when an item is taken.
  assign lim_sat = (32'(lim_cfg_r) > NUM_ENTRIES) ? LimW'(NUM_ENTRIES) : LimW'(lim_cfg_r);

  // Quotient estimate by reciprocal; at most one low, fixed in the next step.
  assign prod = ProdW'(idx_r) * ProdW'(Recip);
  assign rem  = idx_r - IdxW'(32'(q_r) * WORD_BITS);

  assign rd_issue = cmd.scan && (base_rd_r < CntW'(lim_r));
  assign span     = CntW'(lim_r) - base_chk_r;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      span_mask[i] = span > CntW'(i);
    end
  end

  assign avail = ~rd_data_r & span_mask;

  always_comb begin
    low_b = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        low_b = BitW'(i);
      end
    end
  end

  assign grant     = base_chk_r + CntW'(low_b);
  assign found     = cmd.scan && chk_vld_r && (|avail);
  assign exhausted = cmd.scan && !chk_vld_r && !rd_issue;

  assign stat.clr_done  = cmd.clear && (clr_cnt_r == AddrW'(MapWords - 1));
  assign stat.found     = found;
  assign stat.exhausted = exhausted;
  assign stat.out_free  = !out_vld_r || out_tready;

  assign mem_we = cmd.clear || (cmd.commit && wr_pend_r);
  assign mem_wa = cmd.clear ? clr_cnt_r : wr_word_r;
  assign mem_wd = cmd.clear ? '0 : wr_data_r;
  assign mem_re = cmd.free_rd || rd_issue;
  assign mem_ra = cmd.free_rd ? word_r : rd_w_r[AddrW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_cfg_r <= bffa_pkg::LIMIT_RST;
      clr_cnt_r <= '0;
      chk_vld_r <= 1'b0;
      wr_pend_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lim_cfg_r <= cfg_wr_data;
      end
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.accept) begin
        chk_vld_r <= 1'b0;
      end else if (cmd.scan) begin
        chk_vld_r <= rd_issue;
      end
      if (cmd.free_mod) begin
        wr_pend_r <= inrange_r;
      end else if (found) begin
        wr_pend_r <= 1'b1;
      end else if (exhausted) begin
        wr_pend_r <= 1'b0;
      end
      if (cmd.commit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r     <= in_index;
      lim_r     <= lim_sat;
      rd_w_r    <= '0;
      base_rd_r <= '0;
    end
    if (rd_issue) begin
      rd_w_r     <= rd_w_r + 1'b1;
      base_rd_r  <= base_rd_r + CntW'(WORD_BITS);
      word_chk_r <= rd_w_r[AddrW-1:0];
      base_chk_r <= base_rd_r;
    end
    if (cmd.div) begin
      q_r <= prod[ProdW-1:bffa_pkg::RECIP_SH];
    end
    if (cmd.free_adr) begin
      inrange_r <= 32'(idx_r) < NUM_ENTRIES;
      if (rem >= IdxW'(WORD_BITS)) begin
        word_r <= AddrW'(q_r + 1'b1);
        bit_r  <= BitW'(rem - IdxW'(WORD_BITS));
      end else begin
        word_r <= AddrW'(q_r);
        bit_r  <= BitW'(rem);
      end
    end
    if (cmd.free_mod) begin
      wr_word_r    <= word_r;
      wr_data_r    <= rd_data_r & ~(WORD_BITS'(1) << bit_r);
      res_status_r <= bffa_pkg::STATUS_OK;
      res_idx_r    <= idx_r;
    end else if (found) begin
      wr_word_r    <= word_chk_r;
      wr_data_r    <= rd_data_r | (WORD_BITS'(1) << low_b);
      res_status_r <= bffa_pkg::STATUS_OK;
      res_idx_r    <= IdxW'(grant);
    end else if (exhausted) begin
      res_status_r <= bffa_pkg::STATUS_NO_SPACE;
      res_idx_r    <= '0;
    end
    if (cmd.commit) begin
      out_status_r <= res_status_r;
      out_idx_r    <= res_idx_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_status = out_status_r;
  assign out_index  = out_idx_r;

`ifndef ASSERT_OFF
  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_vld_r || out_tready))
    else $error("result committed over an untaken result");

  a_grant_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    found |-> (grant < CntW'(lim_r)))
    else $error("granted entry at or above the limit");

  a_scan_addr_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    rd_issue |-> (rd_w_r < (AddrW + 1)'(MapWords)))
    else $error("scan read beyond the map");
`endif

endmodule

### hw/rtl/bitmap_first_free_allocator_unit.sv
// Top level of the first-fit bitmap allocator.
`timescale 1ns / 1ps

// First-fit bitmap allocator. One used bit per entry, packed into map words
// of WORD_BITS bits, entry i at bit (i mod WORD_BITS) of word (i / WORD_BITS).
// Input beat: in_tuser is the request kind (0 allocate, 1 free), in_tdata
// carries the entry index to free. Every input beat yields exactly one
// output beat: out_tuser is the status (0 ok, 1 no free entry within the
// limit), out_tdata the granted index, the freed index echoed, or zero.
// cfg_wr_en/cfg_wr_data write the entry limit (reset 32768); write it only
// while the block is idle.
// After reset the block sweeps all ceil(NUM_ENTRIES / WORD_BITS) map words
// to zero, one word per cycle, with in_tready low. A free passes through
// divide, address, read, modify and commit steps from acceptance to the
// output register. An allocate reads one map word per cycle through the
// single memory read port; a hit ends the scan at the first word with a
// free entry below the limit, and a miss ends it once every word below the
// limit has been read. One request is in work at a time; in_tready returns
// the cycle after the commit. The output register holds a result until
// out_tready; a new request is accepted meanwhile, and the block waits
// only when it must publish the next result while the previous one is
// still untaken.
module bitmap_first_free_allocator_unit #(
  parameter int NUM_ENTRIES = bffa_pkg::NUM_ENTRIES_DEF,
  parameter int WORD_BITS   = bffa_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bffa_pkg::LIMIT_W-1:0]  cfg_wr_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bffa_pkg::TDATA_W-1:0]  in_tdata,   // [14:0] entry_index, [15] zero
  input  logic [bffa_pkg::TUSER_W-1:0]  in_tuser,   // [0] req_type
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bffa_pkg::TDATA_W-1:0]  out_tdata,  // [14:0] granted_index, [15] zero
  output logic [bffa_pkg::TUSER_W-1:0]  out_tuser   // [0] status
);

  bffa_pkg::ctrl_cmd_t            cmd;
  bffa_pkg::dp_stat_t             stat;
  logic                           out_status;
  logic [bffa_pkg::IDX_W-1:0]     out_index;

  // The controller sequences the clearing pass, free and scan phases.
  bffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_req    (in_tuser[0]),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath owns the map memory, the counters and the output register.
  bffa_dpath #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .WORD_BITS   (WORD_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_index    (in_tdata[bffa_pkg::IDX_W-1:0]),
    .cmd         (cmd),
    .stat        (stat),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_status  (out_status),
    .out_index   (out_index)
  );

  assign out_tdata = bffa_pkg::TDATA_W'(out_index);
  assign out_tuser = bffa_pkg::TUSER_W'(out_status);

endmodule
